// File: rtl/core/lbhr_pkg.sv
// shared types, widths and codes of the length binned hit ratio engine
`default_nettype none
package lbhr_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;

  localparam int CMD_W      = 3;
  localparam int ID_W       = 31;
  localparam int LEN_W      = 24;
  localparam int HITS_W     = 16;
  localparam int BS_W       = 11;
  localparam int TOL_W      = 9;
  localparam int TOT_W      = 24;
  localparam int ST_W       = 3;
  localparam int RATIO_W    = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int SUM_W      = HITS_W + BS_W;
  localparam int NUM_W      = SUM_W + BS_W;
  localparam int FRAC_W     = 16;
  localparam int DIV_NW     = NUM_W + FRAC_W;
  localparam int DIV_DW     = BS_W + TOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);
  localparam int MUL_TW     = TOL_W + BS_W;

  localparam logic [HITS_W-1:0]  HITS_MAX  = '1;
  localparam logic [TOT_W-1:0]   TOT_MAX   = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  localparam logic [BS_W-1:0]   RST_BIN_SIZE  = BS_W'(64);
  localparam logic [TOL_W-1:0]  RST_TOLERANCE = TOL_W'(205);
  localparam logic [LEN_W-1:0]  RST_MIN_LEN   = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_HIT    = 3'd2,
    CMD_FINISH = 3'd3,
    CMD_NEXT   = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_UNKNOWN = 3'd2,
    STS_PHASE   = 3'd3,
    STS_NOHITS  = 3'd4,
    STS_NOBINS  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_BINNING = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_SIZE   = 2'd0,
    CFG_TOLERANCE  = 2'd1,
    CFG_MIN_LENGTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HREAD, ST_HCMP, ST_SORT_I, ST_SKEY, ST_SCMP, ST_SPLACE,
    ST_PICK, ST_PICK_WAIT, ST_BSUM, ST_BMED, ST_BMUL, ST_BDIV, ST_BWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [HITS_W-1:0] hits;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    status_t            status;
    logic [BS_W-1:0]    bin_size_used;
    logic [LEN_W-1:0]   median_len;
    logic [RATIO_W-1:0] ratio_q16;
    logic [BS_W-1:0]    bin_count;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/lbhr_if.sv
// valid/ready channels for command words and result words
`default_nettype none
interface lbhr_in_if;
  logic                        valid;
  logic                        ready;
  logic [lbhr_pkg::CMD_W-1:0]  command;
  logic [lbhr_pkg::ID_W-1:0]   doc_id;
  logic [lbhr_pkg::LEN_W-1:0]  doc_len;
  modport source (output valid, command, doc_id, doc_len, input ready);
  modport sink   (input valid, command, doc_id, doc_len, output ready);
endinterface

interface lbhr_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbhr_pkg::ST_W-1:0]     status;
  logic [lbhr_pkg::BS_W-1:0]     bin_size_used;
  logic [lbhr_pkg::LEN_W-1:0]    median_len;
  logic [lbhr_pkg::RATIO_W-1:0]  ratio_q16;
  logic [lbhr_pkg::BS_W-1:0]     bin_count;
  logic                          last;
  modport source (output valid, status, bin_size_used, median_len, ratio_q16, bin_count,
                  last, input ready);
  modport sink   (input valid, status, bin_size_used, median_len, ratio_q16, bin_count,
                  last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/length_binned_hit_ratio_engine_unit.sv
// top level: command sequencer around the document table and the divider
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    command, doc_id, doc_len
//   out_ch   out  valid/ready    status, bin_size_used, median_len, ratio_q16,
//                                bin_count, last
//   cfg_*    in   write enable   cfg_index, cfg_data
//
// one command at a time; clear, load and rejected commands go straight from idle to output
// hit: a read state and a compare state per table entry scanned, stopping at the first match
// finish: insertion sort by length, then id,
//   then one run of the shared divider per bin size tried
// next bin: table reads to sum the hits and fetch the median, then one divider run
// synchronous reset clears control only; the table holds no valid bits
`default_nettype none
module length_binned_hit_ratio_engine_unit #(
  parameter int TABLE_DEPTH = lbhr_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lbhr_in_if.sink                            in_ch,
  lbhr_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lbhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbhr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbhr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = ((CW > BS_W) ? CW : BS_W) + 1;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [BS_W-1:0]   cbs_r, cbs_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [BS_W-1:0]   bin_size_r;
  logic [TOL_W-1:0]  tol_r;
  logic [LEN_W-1:0]  minlen_r;

  logic [ID_W-1:0]   id_r, id_nxt;
  entry_t            key_r, key_nxt;
  logic [CW-1:0]     si_r, si_nxt;
  logic [CW-1:0]     sj_r, sj_nxt;
  logic [BS_W-1:0]   bs_r, bs_nxt;
  logic [CW-1:0]     to_r, to_nxt;
  logic [CW-1:0]     rd_r, rd_nxt;
  logic              pend_r, pend_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr;
  entry_t            mem_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_accept;
  logic              goes_first;
  logic [TW-1:0]     tsum;
  logic [CW:0]       mid;
  logic [MUL_TW-1:0] need_full;
  logic [BS_W-1:0]   rem_bs;
  logic [BS_W-1:0]   bcnt;

  lbhr_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lbhr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    cbs_nxt    = cbs_r;
    cursor_nxt = cursor_r;
    id_nxt     = id_r;
    key_nxt    = key_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    bs_nxt     = bs_r;
    to_nxt     = to_r;
    rd_nxt     = rd_r;
    pend_nxt   = pend_r;
    sum_nxt    = sum_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;

    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = key_r;
    mem_raddr     = '0;
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'(count_r);
    div_req.den   = DIV_DW'(bs_r);

    goes_first = (key_r.len != mem_rdata.len) ? (key_r.len < mem_rdata.len)
                                               : (key_r.id < mem_rdata.id);
    tsum       = TW'(cursor_r) + TW'(cbs_r);
    mid        = ((CW+1)'(cursor_r) + (CW+1)'(to_r)) >> 1;
    need_full  = MUL_TW'(tol_r) * MUL_TW'(bs_r);
    rem_bs     = div_rsp.rem[BS_W-1:0];
    bcnt       = BS_W'(to_r - cursor_r);

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_nxt        = '0;
          res_nxt.status = STS_OK;
          id_nxt         = in_ch.doc_id;
          state_nxt      = ST_OUT;
          case (cmd_t'(in_ch.command))
            CMD_CLEAR: begin
              count_nxt  = '0;
              total_nxt  = '0;
              cbs_nxt    = '0;
              cursor_nxt = '0;
              phase_nxt  = PH_LOADING;
            end
            CMD_LOAD: begin
              if (phase_r != PH_LOADING) begin
                res_nxt.status = STS_PHASE;
              end else if (in_ch.doc_len >= minlen_r) begin
                if (count_r >= CW'(TABLE_DEPTH)) begin
                  res_nxt.status = STS_FULL;
                end else begin
                  mem_we         = 1'b1;
                  mem_waddr      = count_r[AW-1:0];
                  mem_wdata.id   = in_ch.doc_id;
                  mem_wdata.len  = in_ch.doc_len;
                  mem_wdata.hits = '0;
                  count_nxt      = count_r + CW'(1);
                end
              end
            end
            CMD_HIT: begin
              if (phase_r != PH_LOADING) begin
                res_nxt.status = STS_PHASE;
              end else if (count_r == '0) begin
                res_nxt.status = STS_UNKNOWN;
              end else begin
                si_nxt    = '0;
                state_nxt = ST_HREAD;
              end
            end
            CMD_FINISH: begin
              if (phase_r != PH_LOADING) begin
                res_nxt.status = STS_PHASE;
              end else if (count_r == '0) begin
                res_nxt.status = STS_NOBINS;
              end else if (total_r == '0) begin
                res_nxt.status = STS_NOHITS;
              end else begin
                si_nxt    = CW'(1);
                bs_nxt    = (bin_size_r == '0) ? BS_W'(1) : bin_size_r;
                state_nxt = ST_SORT_I;
              end
            end
            CMD_NEXT: begin
              if (phase_r == PH_LOADING) begin
                res_nxt.status = STS_PHASE;
              end else if (phase_r == PH_DONE || cursor_r >= count_r) begin
                res_nxt.status = STS_NOBINS;
              end else begin
                to_nxt    = (tsum > TW'(count_r)) ? count_r : CW'(tsum);
                rd_nxt    = cursor_r;
                pend_nxt  = 1'b0;
                sum_nxt   = '0;
                state_nxt = ST_BSUM;
              end
            end
            default: res_nxt.status = STS_PHASE;
          endcase
        end
      end

      // linear search, earliest matching entry wins
      ST_HREAD: begin
        mem_raddr = si_r[AW-1:0];
        state_nxt = ST_HCMP;
      end
      ST_HCMP: begin
        if (mem_rdata.id == id_r) begin
          mem_we         = 1'b1;
          mem_waddr      = si_r[AW-1:0];
          mem_wdata      = mem_rdata;
          mem_wdata.hits = (mem_rdata.hits == HITS_MAX) ? HITS_MAX
                                                         : mem_rdata.hits + HITS_W'(1);
          total_nxt      = (total_r == TOT_MAX) ? TOT_MAX : total_r + TOT_W'(1);
          state_nxt      = ST_OUT;
        end else if (si_r + CW'(1) >= count_r) begin
          res_nxt.status = STS_UNKNOWN;
          state_nxt      = ST_OUT;
        end else begin
          si_nxt    = si_r + CW'(1);
          state_nxt = ST_HREAD;
        end
      end

      // insertion sort by length, then id
      ST_SORT_I: begin
        if (si_r >= count_r) begin
          state_nxt = ST_PICK;
        end else begin
          mem_raddr = si_r[AW-1:0];
          state_nxt = ST_SKEY;
        end
      end
      ST_SKEY: begin
        key_nxt   = mem_rdata;
        sj_nxt    = si_r;
        mem_raddr = AW'(si_r - CW'(1));
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        mem_we    = 1'b1;
        mem_waddr = sj_r[AW-1:0];
        if (goes_first) begin
          mem_wdata = mem_rdata;
          sj_nxt    = sj_r - CW'(1);
          if (sj_r == CW'(1)) begin
            state_nxt = ST_SPLACE;
          end else begin
            mem_raddr = AW'(sj_r - CW'(2));
          end
        end else begin
          mem_wdata = key_r;
          si_nxt    = si_r + CW'(1);
          state_nxt = ST_SORT_I;
        end
      end
      ST_SPLACE: begin
        mem_we    = 1'b1;
        mem_waddr = sj_r[AW-1:0];
        mem_wdata = key_r;
        si_nxt    = si_r + CW'(1);
        state_nxt = ST_SORT_I;
      end

      // shrink bin size until the last bin is empty or full enough, or size is 1
      ST_PICK: begin
        div_req.start = 1'b1;
        state_nxt     = ST_PICK_WAIT;
      end
      ST_PICK_WAIT: begin
        if (div_rsp.done) begin
          if (rem_bs == '0 || MUL_TW'(rem_bs) >= (need_full >> 8) || bs_r <= BS_W'(1)) begin
            cbs_nxt    = bs_r;
            cursor_nxt = '0;
            phase_nxt  = PH_BINNING;
            state_nxt  = ST_OUT;
          end else begin
            bs_nxt    = bs_r - BS_W'(1);
            state_nxt = ST_PICK;
          end
        end
      end

      // one read issued per cycle, hits added as data returns
      ST_BSUM: begin
        if (pend_r) begin
          sum_nxt = sum_r + SUM_W'(mem_rdata.hits);
        end
        if (rd_r < to_r) begin
          mem_raddr = rd_r[AW-1:0];
          rd_nxt    = rd_r + CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_BMED;
          end
        end
      end
      ST_BMED: begin
        mem_raddr = mid[AW-1:0];
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        res_nxt.median_len = mem_rdata.len;
        res_nxt.bin_count  = bcnt;
        num_nxt            = NUM_W'(sum_r) * NUM_W'(cbs_r);
        den_nxt            = DIV_DW'(bcnt) * DIV_DW'(total_r);
        state_nxt          = ST_BDIV;
      end
      ST_BDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {num_r, {FRAC_W{1'b0}}};
        div_req.den   = den_r;
        state_nxt     = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (div_rsp.done) begin
          res_nxt.ratio_q16 = (div_rsp.quot > DIV_NW'(RATIO_MAX)) ? RATIO_MAX
                                                                  : div_rsp.quot[RATIO_W-1:0];
          cursor_nxt = to_r;
          if (to_r >= count_r) begin
            res_nxt.last = 1'b1;
            phase_nxt    = PH_DONE;
          end
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!ovalid_r || out_ch.ready) begin
          out_nxt               = res_r;
          out_nxt.bin_size_used = cbs_r;
          ovalid_nxt            = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_LOADING;
      count_r    <= '0;
      total_r    <= '0;
      cbs_r      <= '0;
      cursor_r   <= '0;
      ovalid_r   <= 1'b0;
      pend_r     <= 1'b0;
      bin_size_r <= RST_BIN_SIZE;
      tol_r      <= RST_TOLERANCE;
      minlen_r   <= RST_MIN_LEN;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      cbs_r    <= cbs_nxt;
      cursor_r <= cursor_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BIN_SIZE:   bin_size_r <= cfg_data[BS_W-1:0];
          CFG_TOLERANCE:  tol_r      <= cfg_data[TOL_W-1:0];
          CFG_MIN_LENGTH: minlen_r   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    id_r  <= id_nxt;
    key_r <= key_nxt;
    si_r  <= si_nxt;
    sj_r  <= sj_nxt;
    bs_r  <= bs_nxt;
    to_r  <= to_nxt;
    rd_r  <= rd_nxt;
    sum_r <= sum_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.bin_size_used = out_r.bin_size_used;
  assign out_ch.median_len    = out_r.median_len;
  assign out_ch.ratio_q16     = out_r.ratio_q16;
  assign out_ch.bin_count     = out_r.bin_count;
  assign out_ch.last          = out_r.last;

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("document count beyond table depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("bin cursor past document count");

  a_binning_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_LOADING) |-> (total_r != '0 && cbs_r != '0 && count_r != '0))
    else $error("binning phase without hits, bins or documents");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_IDLE) |-> in_accept)
    else $error("table written while idle without a load word");

endmodule
`default_nettype wire

// File: rtl/core/lbhr_mem.sv
// document table memory, one write and one registered read per cycle
`default_nettype none
module lbhr_mem #(
  parameter int TABLE_DEPTH = lbhr_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  wire lbhr_pkg::entry_t               wdata,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  output      lbhr_pkg::entry_t               rdata
);
  import lbhr_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/lbhr_div.sv
// restoring divider, one quotient bit per cycle, shared by bin pick and ratio
`default_nettype none
module lbhr_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lbhr_pkg::div_req_t req,
  output      lbhr_pkg::div_rsp_t rsp
);
  import lbhr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0]    n_r, n_nxt;
  logic [DIV_DW:0]      r_r, r_nxt;
  logic [DIV_DW-1:0]    d_r, d_nxt;
  logic [DIV_DW:0]      r_sh;
  logic                 ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    r_sh     = {r_r[DIV_DW-1:0], n_r[DIV_NW-1]};
    ge       = r_sh >= {1'b0, d_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NW);
      n_nxt    = req.num;
      r_nxt    = '0;
      d_nxt    = req.den;
    end else if (busy_r) begin
      r_nxt   = ge ? (r_sh - {1'b0, d_r}) : r_sh;
      n_nxt   = {n_r[DIV_NW-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = n_r;
  assign rsp.rem  = r_r[DIV_DW-1:0];

endmodule
`default_nettype wire

// File: sim/lbhr_checker.sv
// checker: predicts each result word from the command stream and compares it
`default_nettype none
module lbhr_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lbhr_in_if                                     in_mon,
  lbhr_out_if                                    out_mon,
  input  wire logic                              cfg_we,
  input  wire logic [lbhr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbhr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                     fail_count,
  output int                                     pending
);
  import lbhr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOCS = DEF_TABLE_DEPTH;

  logic [BS_W-1:0]   bin_size_reg;
  logic [TOL_W-1:0]  tol_reg;
  logic [LEN_W-1:0]  min_len_reg;

  logic [ID_W-1:0]   tbl_id   [DOCS];
  logic [LEN_W-1:0]  tbl_len  [DOCS];
  logic [HITS_W-1:0] tbl_hits [DOCS];
  int unsigned       n_docs;
  logic [TOT_W-1:0]  hit_total;
  logic [BS_W-1:0]   used_bs;
  int unsigned       cursor;
  phase_t            ph;

  result_t expected_words[$];

  assign pending = expected_words.size();

  function automatic int unsigned choose_bin_size();
    int unsigned bs;
    int unsigned rem;
    int unsigned need;
    bs = (bin_size_reg == 0) ? 1 : bin_size_reg;
    forever begin
      rem = n_docs % bs;
      need = (tol_reg * bs) >> 8;
      if (rem == 0 || rem >= need || bs <= 1) break;
      bs--;
    end
    return bs;
  endfunction

  task automatic sort_by_length();
    logic [ID_W-1:0]   kid;
    logic [LEN_W-1:0]  klen;
    logic [HITS_W-1:0] khits;
    int unsigned j;
    for (int unsigned i = 1; i < n_docs; i++) begin
      kid = tbl_id[i];
      klen = tbl_len[i];
      khits = tbl_hits[i];
      j = i;
      while (j > 0 && ((klen != tbl_len[j-1]) ? (klen < tbl_len[j-1])
                                              : (kid < tbl_id[j-1]))) begin
        tbl_id[j] = tbl_id[j-1];
        tbl_len[j] = tbl_len[j-1];
        tbl_hits[j] = tbl_hits[j-1];
        j--;
      end
      tbl_id[j] = kid;
      tbl_len[j] = klen;
      tbl_hits[j] = khits;
    end
  endtask

  task automatic predict_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [LEN_W-1:0] len);
    result_t r;
    int unsigned from;
    int unsigned upto;
    longint unsigned sum;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    r = '0;
    r.status = STS_OK;
    case (cmd)
      CMD_CLEAR: begin
        n_docs = 0;
        hit_total = '0;
        used_bs = '0;
        cursor = 0;
        ph = PH_LOADING;
      end
      CMD_LOAD: begin
        if (ph != PH_LOADING) r.status = STS_PHASE;
        else if (len >= min_len_reg) begin
          if (n_docs >= DOCS) r.status = STS_FULL;
          else begin
            tbl_id[n_docs] = id;
            tbl_len[n_docs] = len;
            tbl_hits[n_docs] = '0;
            n_docs++;
          end
        end
      end
      CMD_HIT: begin
        if (ph != PH_LOADING) r.status = STS_PHASE;
        else begin
          r.status = STS_UNKNOWN;
          for (int unsigned i = 0; i < n_docs; i++) begin
            if (tbl_id[i] == id) begin
              if (tbl_hits[i] != HITS_MAX) tbl_hits[i]++;
              if (hit_total != TOT_MAX) hit_total++;
              r.status = STS_OK;
              break;
            end
          end
        end
      end
      CMD_FINISH: begin
        if (ph != PH_LOADING) r.status = STS_PHASE;
        else if (n_docs == 0) r.status = STS_NOBINS;
        else if (hit_total == 0) r.status = STS_NOHITS;
        else begin
          sort_by_length();
          used_bs = BS_W'(choose_bin_size());
          cursor = 0;
          ph = PH_BINNING;
        end
      end
      CMD_NEXT: begin
        if (ph == PH_LOADING) r.status = STS_PHASE;
        else if (ph == PH_DONE || cursor >= n_docs) r.status = STS_NOBINS;
        else begin
          from = cursor;
          upto = from + used_bs;
          if (upto > n_docs) upto = n_docs;
          sum = 0;
          for (int unsigned i = from; i < upto; i++) sum += tbl_hits[i];
          num = (sum * used_bs) << 16;
          den = longint'(upto - from) * hit_total;
          q = (den != 0) ? num / den : longint'(RATIO_MAX);
          if (q > longint'(RATIO_MAX)) q = longint'(RATIO_MAX);
          r.ratio_q16 = RATIO_W'(q);
          r.bin_count = BS_W'(upto - from);
          r.median_len = tbl_len[((from + upto) / 2) % DOCS];
          cursor = upto;
          if (upto >= n_docs) begin
            r.last = 1'b1;
            ph = PH_DONE;
          end
        end
      end
      default: r.status = STS_PHASE;
    endcase
    r.bin_size_used = used_bs;
    expected_words.push_back(r);
  endtask

  task automatic compare_word();
    result_t e;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected, status %0d", out_mon.status);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    if (out_mon.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_mon.status);
      fail_count++;
    end
    if (out_mon.bin_size_used !== e.bin_size_used) begin
      $error("bin_size_used: expected %0d, got %0d", e.bin_size_used, out_mon.bin_size_used);
      fail_count++;
    end
    if (out_mon.median_len !== e.median_len) begin
      $error("median_len: expected %0d, got %0d", e.median_len, out_mon.median_len);
      fail_count++;
    end
    if (out_mon.ratio_q16 !== e.ratio_q16) begin
      $error("ratio_q16: expected %0d, got %0d", e.ratio_q16, out_mon.ratio_q16);
      fail_count++;
    end
    if (out_mon.bin_count !== e.bin_count) begin
      $error("bin_count: expected %0d, got %0d", e.bin_count, out_mon.bin_count);
      fail_count++;
    end
    if (out_mon.last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, out_mon.last);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      bin_size_reg <= RST_BIN_SIZE;
      tol_reg <= RST_TOLERANCE;
      min_len_reg <= RST_MIN_LEN;
      n_docs = 0;
      hit_total = '0;
      used_bs = '0;
      cursor = 0;
      ph = PH_LOADING;
    end else begin
      if (out_mon.valid && out_mon.ready) compare_word();
      if (in_mon.valid && in_mon.ready)
        predict_word(in_mon.command, in_mon.doc_id, in_mon.doc_len);
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIN_SIZE:   bin_size_reg <= cfg_data[BS_W-1:0];
          CFG_TOLERANCE:  tol_reg <= cfg_data[TOL_W-1:0];
          CFG_MIN_LENGTH: min_len_reg <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: sim/length_binned_hit_ratio_engine_unit_test.sv
// testbench top: clock, reset, command stimulus, result stalls and verdict
`default_nettype none
module length_binned_hit_ratio_engine_unit_test;
  import lbhr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_WORDS = 1950;
  localparam int TAIL_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int words_sent = 0;
  bit no_gaps = 0;
  bit long_hold = 0;
  bit stimulus_done = 0;

  lbhr_in_if  in_ch ();
  lbhr_out_if out_ch ();

  always #1 clk = ~clk;

  length_binned_hit_ratio_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lbhr_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.doc_id = '0;
    in_ch.doc_len = '0;
    out_ch.ready = 1'b0;
  end

  // result side: random stalls per word, plus one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (long_hold) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_word(cmd_t cmd, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
    int idle;
    idle = no_gaps ? 0 : $urandom_range(0, 15);
    if (idle > 0) begin
      in_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.doc_id = id;
    in_ch.doc_len = len;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    words_sent++;
  endtask

  task automatic send_raw(logic [CMD_W-1:0] code);
    send_word(cmd_t'(code), ID_W'($urandom), LEN_W'($urandom));
  endtask

  // waits for the block to drain before writing
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    in_ch.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_bins();
    int extra;
    extra = $urandom_range(0, 2);
    repeat (1100) begin
      send_word(CMD_NEXT, '0, '0);
      wait (pending == 0);
      if (out_ch.last && extra == 0) break;
      if (out_ch.last) extra--;
    end
  endtask

  task automatic random_session();
    logic [ID_W-1:0] pool [8];
    int docs;
    int hits;
    int mode;
    foreach (pool[k]) pool[k] = ($urandom_range(0, 1) == 1) ? ID_W'($urandom) :
                                ID_W'($urandom_range(0, 20));
    mode = $urandom_range(0, 9);
    no_gaps = ($urandom_range(0, 4) == 0);
    send_word(CMD_CLEAR, ID_W'($urandom), LEN_W'($urandom));
    docs = $urandom_range(0, 40);
    for (int k = 0; k < docs; k++) begin
      logic [LEN_W-1:0] len;
      len = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40));
      send_word(CMD_LOAD, pool[$urandom_range(0, 7)], len);
    end
    hits = $urandom_range(0, 50);
    for (int k = 0; k < hits; k++) begin
      if ($urandom_range(0, 9) == 0) send_word(CMD_HIT, ID_W'($urandom), '0);
      else send_word(CMD_HIT, pool[$urandom_range(0, 7)], '0);
      if (mode == 0 && $urandom_range(0, 9) == 0) send_raw(CMD_W'($urandom_range(0, 7)));
    end
    send_word(CMD_FINISH, '0, '0);
    if (mode == 1) begin
      send_word(CMD_LOAD, pool[0], '0);
      send_word(CMD_FINISH, '0, '0);
    end
    if (mode != 2) drain_bins();
    wait (pending == 0);
  endtask

  task automatic random_config();
    int unsigned bs;
    int unsigned tol;
    int unsigned ml;
    case ($urandom_range(0, 5))
      0: bs = 1024;
      1: bs = $urandom_range(0, 2047);
      2: bs = 1;
      default: bs = $urandom_range(1, 12);
    endcase
    tol = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256);
    case ($urandom_range(0, 5))
      0: ml = $urandom_range(0, 30);
      1: ml = $urandom_range(0, 16777215);
      default: ml = 0;
    endcase
    write_reg(CFG_BIN_SIZE, bs);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MIN_LENGTH, ml);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: phase errors, empty and hitless finish, extremes, duplicates
    send_word(CMD_NEXT, '0, '0);
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_LOAD, '0, '0);
    send_word(CMD_LOAD, '1, '1);
    send_word(CMD_HIT, ID_W'(77), '0);
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_LOAD, '0, LEN_W'(5));
    send_word(CMD_HIT, '0, '0);
    send_word(CMD_HIT, '1, '0);
    send_word(CMD_HIT, '0, '0);
    send_raw(3'd5);
    send_raw(3'd6);
    send_raw(3'd7);
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_LOAD, ID_W'(3), LEN_W'(3));
    send_word(CMD_HIT, '0, '0);
    send_word(CMD_FINISH, '0, '0);
    drain_bins();
    send_word(CMD_CLEAR, '0, '0);
    write_reg(CFG_MIN_LENGTH, 10);
    write_reg(CFG_BIN_SIZE, 0);
    write_reg(CFG_TOLERANCE, 256);
    send_word(CMD_LOAD, ID_W'(1), LEN_W'(9));
    send_word(CMD_LOAD, ID_W'(2), LEN_W'(10));
    send_word(CMD_HIT, ID_W'(1), '0);
    send_word(CMD_HIT, ID_W'(2), '0);
    send_word(CMD_FINISH, '0, '0);
    drain_bins();

    // full table: lengths ascending keep the sort short; receiver holds off
    write_reg(CFG_MIN_LENGTH, 0);
    write_reg(CFG_BIN_SIZE, 1024);
    write_reg(CFG_TOLERANCE, 0);
    send_word(CMD_CLEAR, '0, '0);
    no_gaps = 1;
    long_hold = 1;
    for (int k = 0; k < DEF_TABLE_DEPTH; k++)
      send_word(CMD_LOAD, ID_W'(k * 3), LEN_W'(k * 16000));
    no_gaps = 0;
    send_word(CMD_LOAD, ID_W'(9), LEN_W'(9));
    send_word(CMD_HIT, ID_W'(3069), '0);
    send_word(CMD_HIT, ID_W'(0), '0);
    send_word(CMD_FINISH, '0, '0);
    drain_bins();
    send_word(CMD_CLEAR, '0, '0);
    write_reg(CFG_BIN_SIZE, 64);
    write_reg(CFG_TOLERANCE, 205);

    while (words_sent < TARGET_WORDS) begin
      if ($urandom_range(0, 2) == 0) random_config();
      random_session();
    end
    in_ch.valid = 1'b0;
    no_gaps = 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("length_binned_hit_ratio_engine_unit_test: done, clean");
    else
      $display("length_binned_hit_ratio_engine_unit_test: done, errors");
    $finish;
  end

  // worst case is a long bin size search on every finish
  initial begin
    #2_000_000_000;
    $display("length_binned_hit_ratio_engine_unit_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/lbhr_pkg.sv
rtl/core/lbhr_if.sv
rtl/core/lbhr_mem.sv
rtl/core/lbhr_div.sv
rtl/core/length_binned_hit_ratio_engine_unit.sv
sim/lbhr_checker.sv
sim/length_binned_hit_ratio_engine_unit_test.sv
